// ----- rtl/core/pwrfs_pkg.sv -----
// Shared types and constants of the pulse-width remote frame sender.
package pwrfs_pkg;

	// Width of the data portion of each burst (low bits of the code word).
	localparam int SENT_BITS = 51;
	localparam int IDX_W     = $clog2(SENT_BITS);
	localparam int CODE_W    = 52;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 88;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_TIME    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TIME    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_TOTAL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_TOTAL   = 3'd5;

	// Input mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PULSE = 1'b1;

	typedef struct packed {
		logic [11:0] short_time;
		logic [11:0] long_time;
		logic [9:0]  tolerance_time;
		logic [15:0] gap_time;
		logic [2:0]  burst_total;
		logic [3:0]  header_pair_total;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_word;
		logic [15:0]       next_counter;
		logic              line_level;
		logic [15:0]       pulse_time;
		logic              frame_end;
		logic              idle_flag;
	} result_t;

endpackage

// ----- rtl/core/pwrfs_cfg_regs.sv -----
// Configuration register file of the pulse-width remote frame sender.
module pwrfs_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pwrfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwrfs_pkg::CFG_DATA_W-1:0] cfg_data,
	output pwrfs_pkg::cfg_t                  cfg
);
	import pwrfs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_time        <= 12'd750;
			cfg_q.long_time         <= 12'd1100;
			cfg_q.tolerance_time    <= 10'd160;
			cfg_q.gap_time          <= 16'd15000;
			cfg_q.burst_total       <= 3'd3;
			cfg_q.header_pair_total <= 4'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_TIME:  cfg_q.short_time        <= cfg_data[11:0];
				REG_LONG_TIME:   cfg_q.long_time         <= cfg_data[11:0];
				REG_TOL_TIME:    cfg_q.tolerance_time    <= cfg_data[9:0];
				REG_GAP_TIME:    cfg_q.gap_time          <= cfg_data;
				REG_BURST_TOTAL: cfg_q.burst_total       <= cfg_data[2:0];
				REG_HDR_TOTAL:   cfg_q.header_pair_total <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/pwrfs_pulse_seq.sv -----
// Frame packer and burst pulse sequencer: builds one result per transaction.
module pwrfs_pulse_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pwrfs_pkg::cfg_t      cfg,
	input  logic                 fire,
	input  logic                 mode,
	input  logic [27:0]          serial,
	input  logic [3:0]           button,
	input  logic [15:0]          counter,
	output pwrfs_pkg::result_t   res
);
	import pwrfs_pkg::*;

	localparam logic [2:0] SEG_HEADER = 3'd0;
	localparam logic [2:0] SEG_SYNC   = 3'd1;
	localparam logic [2:0] SEG_DATA   = 3'd2;
	localparam logic [2:0] SEG_STOP   = 3'd3;
	localparam logic [2:0] SEG_GAP    = 3'd4;

	logic [SENT_BITS-1:0] frame_bits_q, frame_bits_d;
	logic [1:0]           burst_q, burst_d;
	logic [2:0]           seg_q, seg_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic                 low_q, low_d;
	logic                 sending_q, sending_d;

	logic [3:0]  eff_hdr;
	logic [2:0]  eff_bursts;
	logic [2:0]  seg_v;
	logic [IDX_W-1:0] idx_v;
	logic        low_v;
	logic [IDX_W-1:0] idx_inc;
	logic [2:0]  burst_inc;
	logic [15:0] nctr;
	logic [CODE_W-1:0] code;
	logic [63:0] code_ext;

	assign eff_hdr    = (cfg.header_pair_total > 4'd8) ? 4'd8 : cfg.header_pair_total;
	assign eff_bursts = (cfg.burst_total == 3'd0) ? 3'd1 :
	                    (cfg.burst_total > 3'd4) ? 3'd4 : cfg.burst_total;

	assign nctr     = counter + 16'd1;
	assign code     = {serial, button, ~button, nctr};
	assign code_ext = 64'(code);

	always_comb begin
		frame_bits_d = frame_bits_q;
		burst_d      = burst_q;
		seg_d        = seg_q;
		idx_d        = idx_q;
		low_d        = low_q;
		sending_d    = sending_q;
		res          = '0;
		seg_v        = seg_q;
		idx_v        = idx_q;
		low_v        = low_q;
		idx_inc      = idx_q + IDX_W'(1);
		burst_inc    = 3'(burst_q) + 3'd1;

		if (mode == MODE_LOAD) begin
			res.code_word    = code;
			res.next_counter = nctr;
			frame_bits_d     = code_ext[SENT_BITS-1:0];
			burst_d          = 2'd0;
			sending_d        = 1'b1;
			seg_d            = SEG_HEADER;
			idx_d            = '0;
			low_d            = 1'b0;
		end else if (!sending_q) begin
			res.idle_flag = 1'b1;
		end else begin
			// A lowered header count skips the rest of the header
			if (seg_q == SEG_HEADER && idx_q >= IDX_W'(eff_hdr)) begin
				seg_v = SEG_SYNC;
				idx_v = '0;
				low_v = 1'b0;
			end
			idx_inc = idx_v + IDX_W'(1);
			seg_d   = seg_v;
			idx_d   = idx_v;
			low_d   = ~low_v;
			case (seg_v)
				SEG_HEADER: begin
					res.line_level = ~low_v;
					res.pulse_time = {3'b000, cfg.short_time, 1'b0};
					if (low_v) begin
						if (idx_inc >= IDX_W'(eff_hdr)) begin
							seg_d = SEG_SYNC;
							idx_d = '0;
						end else begin
							idx_d = idx_inc;
						end
					end
				end
				SEG_SYNC: begin
					res.line_level = ~low_v;
					res.pulse_time = 16'(cfg.short_time);
					if (low_v) begin
						seg_d = SEG_DATA;
						idx_d = IDX_W'(SENT_BITS - 1);
					end
				end
				SEG_DATA: begin
					res.line_level = ~low_v;
					res.pulse_time = frame_bits_q[idx_v] ? 16'(cfg.long_time)
					                                     : 16'(cfg.short_time);
					if (low_v) begin
						if (idx_v == '0) seg_d = SEG_STOP;
						else idx_d = idx_v - IDX_W'(1);
					end
				end
				SEG_STOP: begin
					res.line_level = 1'b1;
					res.pulse_time = 16'(cfg.long_time) + 16'({cfg.tolerance_time, 1'b0});
					seg_d = SEG_GAP;
					low_d = 1'b0;
				end
				default: begin
					res.line_level = 1'b0;
					res.pulse_time = cfg.gap_time;
					burst_d        = burst_inc[1:0];
					if (burst_inc >= eff_bursts) begin
						res.frame_end = 1'b1;
						sending_d     = 1'b0;
						burst_d       = 2'd0;
					end
					seg_d = SEG_HEADER;
					idx_d = '0;
					low_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bits_q <= '0;
			burst_q      <= 2'd0;
			seg_q        <= SEG_HEADER;
			idx_q        <= '0;
			low_q        <= 1'b0;
			sending_q    <= 1'b0;
		end else if (fire) begin
			frame_bits_q <= frame_bits_d;
			burst_q      <= burst_d;
			seg_q        <= seg_d;
			idx_q        <= idx_d;
			low_q        <= low_d;
			sending_q    <= sending_d;
		end
	end

	a_load_arms: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == MODE_LOAD |=> sending_q && seg_q == SEG_HEADER && burst_q == 2'd0
		&& idx_q == '0 && !low_q)
		else $error("load did not arm the frame from its first header pulse");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.frame_end |=> !sending_q)
		else $error("sender still active after frame end");

	a_idle_req: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == MODE_PULSE && !sending_q |-> res.idle_flag && res.pulse_time == 16'd0)
		else $error("request while idle not flagged");

	a_data_idx: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q == SEG_DATA |-> idx_q <= IDX_W'(SENT_BITS - 1))
		else $error("data bit index out of range");

endmodule

// ----- rtl/core/pulse_width_remote_frame_sender_unit.sv -----
// Top level of the pulse-width remote frame sender.
//
// Input stream (s_*): one transaction per item. s_tuser is the mode: 0 loads
// a frame from serial, button and counter; 1 requests the next pulse.
// Output stream (m_*): one result transaction for every input transaction,
// in order. Load results carry the code word and the incremented counter;
// pulse results carry line level and duration. m_tlast marks the final gap
// of the final burst, m_tuser flags a pulse request made while idle.
// Configuration: cfg_we writes cfg_data into the register at cfg_index;
// write only while no transaction is in flight.
// Path from input transaction to result: an input register, then the single-pass
// sequencer stage into the result register. Throughput is one item per cycle
// while the receiver does not stall, set by that one sequencer stage.
// Reset clears both stages and arms no frame; registers return to defaults.
// When the receiver stalls, the result register holds, the input register
// holds its item, and s_tready drops once both are full.
module pulse_width_remote_frame_sender_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pwrfs_pkg::IN_DATA_W-1:0]    s_tdata,  // serial, button, counter
	input  logic                               s_tuser,  // mode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pwrfs_pkg::OUT_DATA_W-1:0]   m_tdata,  // code_word, next_counter,
	                                                     // line_level, pulse_time
	output logic                               m_tuser,  // idle_flag
	output logic                               m_tlast,  // frame_end
	input  logic                               cfg_we,
	input  logic [pwrfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pwrfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pwrfs_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t result_s2;

	logic        valid_s1, valid_s2;
	logic        mode_s1;
	logic [27:0] serial_s1;
	logic [3:0]  button_s1;
	logic [15:0] counter_s1;
	logic        advance;
	logic        fire;

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	pwrfs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwrfs_pulse_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.mode    (mode_s1),
		.serial  (serial_s1),
		.button  (button_s1),
		.counter (counter_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance)  valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1    <= s_tuser;
			serial_s1  <= s_tdata[27:0];
			button_s1  <= s_tdata[31:28];
			counter_s1 <= s_tdata[47:32];
		end
		if (fire) result_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, result_s2.pulse_time, result_s2.line_level,
	                   result_s2.next_counter, result_s2.code_word};
	assign m_tuser  = result_s2.idle_flag;
	assign m_tlast  = result_s2.frame_end;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(mode_s1) && $stable(counter_s1))
		else $error("stalled input item lost");

	a_fill_s2: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("sequenced item not presented");

	a_no_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input accepted with both stages full and stalled");

endmodule

// ----- dv/pulse_width_remote_frame_sender_unit_tb.sv -----
// Self-checking stream testbench for the pulse-width remote frame sender unit.
module pulse_width_remote_frame_sender_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pwrfs_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [27:0] serial;
		logic [3:0]  button;
		logic [15:0] counter;
	} request_t;

	typedef enum logic [2:0] {PH_HEADER, PH_SYNC, PH_DATA, PH_STOP, PH_GAP} burst_part_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // serial, button, counter
	logic                  s_tuser = 1'b0; // mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // code_word, next_counter, line_level, pulse_time
	logic                  m_tuser;        // idle_flag
	logic                  m_tlast;        // frame_end
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pulse_width_remote_frame_sender_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow registers and sequencer state of the block
	cfg_t              shadow_cfg;
	logic [SENT_BITS-1:0] armed_code = '0;
	int                burst_num = 0;
	burst_part_t       part = PH_HEADER;
	int                part_pos = 0;
	logic              second_half = 1'b0;
	logic              armed = 1'b0;

	request_t          queued_requests[$];
	result_t           pending_results[$];
	request_t          on_bus;
	int unsigned       send_idle_pct = 14;
	int unsigned       recv_idle_pct = 51;
	logic              hold_trigger = 1'b0;
	int unsigned       hold_left = 0;

	int unsigned       mismatch_total = 0;
	int unsigned       requests_taken = 0;
	int unsigned       loads_taken = 0;
	int unsigned       frames_done = 0;
	int unsigned       idle_replies = 0;

	function automatic int unsigned header_limit();
		return (shadow_cfg.header_pair_total > 4'd8) ? 8 : shadow_cfg.header_pair_total;
	endfunction

	function automatic int unsigned burst_limit();
		if (shadow_cfg.burst_total == 3'd0) return 1;
		return (shadow_cfg.burst_total > 3'd4) ? 4 : shadow_cfg.burst_total;
	endfunction

	// Advance the sequencer by one transaction and return the result it produces
	function automatic result_t compute_pulse_result(request_t req);
		result_t     r;
		logic [15:0] bumped;
		r = '0;
		if (req.mode == MODE_LOAD) begin
			bumped         = req.counter + 16'd1;
			r.next_counter = bumped;
			r.code_word    = {req.serial, req.button, ~req.button, bumped};
			armed_code     = SENT_BITS'(r.code_word);
			burst_num      = 0;
			armed          = 1'b1;
			part           = PH_HEADER;
			part_pos       = 0;
			second_half    = 1'b0;
			loads_taken++;
		end else if (!armed) begin
			r.idle_flag = 1'b1;
			idle_replies++;
		end else begin
			// header count may have been lowered under a running frame
			if (part == PH_HEADER && part_pos >= header_limit()) begin
				part        = PH_SYNC;
				part_pos    = 0;
				second_half = 1'b0;
			end
			case (part)
				PH_HEADER: begin
					r.line_level = ~second_half;
					r.pulse_time = 16'(shadow_cfg.short_time) * 16'd2;
					if (second_half) begin
						part_pos++;
						if (part_pos >= header_limit()) begin
							part     = PH_SYNC;
							part_pos = 0;
						end
					end
					second_half = ~second_half;
				end
				PH_SYNC: begin
					r.line_level = ~second_half;
					r.pulse_time = 16'(shadow_cfg.short_time);
					if (second_half) begin
						part     = PH_DATA;
						part_pos = SENT_BITS - 1;
					end
					second_half = ~second_half;
				end
				PH_DATA: begin
					r.line_level = ~second_half;
					r.pulse_time = armed_code[part_pos] ? 16'(shadow_cfg.long_time)
					                                    : 16'(shadow_cfg.short_time);
					if (second_half) begin
						if (part_pos == 0) part = PH_STOP;
						else part_pos--;
					end
					second_half = ~second_half;
				end
				PH_STOP: begin
					r.line_level = 1'b1;
					r.pulse_time = 16'(shadow_cfg.long_time) +
					               16'(shadow_cfg.tolerance_time) * 16'd2;
					part         = PH_GAP;
					second_half  = 1'b0;
				end
				default: begin
					r.pulse_time = shadow_cfg.gap_time;
					burst_num++;
					if (burst_num >= burst_limit()) begin
						r.frame_end = 1'b1;
						armed       = 1'b0;
						burst_num   = 0;
						frames_done++;
					end
					part        = PH_HEADER;
					part_pos    = 0;
					second_half = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

	function automatic int unsigned frame_length();
		return burst_limit() * (2 * header_limit() + 2 + 2 * SENT_BITS + 2);
	endfunction

	// Driver: offer queued requests, predict on every accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(compute_pulse_result(on_bus));
				requests_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = queued_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {on_bus.counter, on_bus.button, on_bus.serial};
					s_tuser  <= on_bus.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_trigger) begin
			hold_left <= 400;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compare each result transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.code_word    = m_tdata[51:0];
				seen.next_counter = m_tdata[67:52];
				seen.line_level   = m_tdata[68];
				seen.pulse_time   = m_tdata[84:69];
				seen.frame_end    = m_tlast;
				seen.idle_flag    = m_tuser;
				if (pending_results.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("%0t: unexpected result code=%h ctr=%h lvl=%b dur=%0d end=%b idle=%b",
						         $realtime, seen.code_word, seen.next_counter,
						         seen.line_level, seen.pulse_time, seen.frame_end,
						         seen.idle_flag);
				end else begin
					want = pending_results.pop_front();
					if (seen.code_word !== want.code_word ||
					    seen.next_counter !== want.next_counter ||
					    seen.line_level !== want.line_level ||
					    seen.pulse_time !== want.pulse_time ||
					    seen.frame_end !== want.frame_end ||
					    seen.idle_flag !== want.idle_flag) begin
						mismatch_total++;
						if (mismatch_total <= 10) begin
							$display("%0t: expected code=%h ctr=%h lvl=%b dur=%0d end=%b idle=%b",
							         $realtime, want.code_word, want.next_counter,
							         want.line_level, want.pulse_time, want.frame_end,
							         want.idle_flag);
							$display("%0t:   actual code=%h ctr=%h lvl=%b dur=%0d end=%b idle=%b",
							         $realtime, seen.code_word, seen.next_counter,
							         seen.line_level, seen.pulse_time, seen.frame_end,
							         seen.idle_flag);
						end
					end
				end
			end
			m_tready <= (hold_left == 0) && !hold_trigger &&
			            ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_request(logic mode, logic [27:0] serial, logic [3:0] button,
	                            logic [15:0] counter);
		request_t req;
		req.mode    = mode;
		req.serial  = serial;
		req.button  = button;
		req.counter = counter;
		queued_requests.push_back(req);
	endtask

	task automatic push_pulses(int unsigned count);
		repeat (count) push_request(MODE_PULSE, 28'($urandom), 4'($urandom), 16'($urandom));
	endtask

	task automatic wait_drained();
		while (queued_requests.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		// let the two pipeline stages settle before touching registers
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_SHORT_TIME:  shadow_cfg.short_time        = value[11:0];
			REG_LONG_TIME:   shadow_cfg.long_time         = value[11:0];
			REG_TOL_TIME:    shadow_cfg.tolerance_time    = value[9:0];
			REG_GAP_TIME:    shadow_cfg.gap_time          = value;
			REG_BURST_TOTAL: shadow_cfg.burst_total       = value[2:0];
			REG_HDR_TOTAL:   shadow_cfg.header_pair_total = value[3:0];
			default: ;
		endcase
	endtask

	// Well-formed frames with random content, cut short or run past the end, plus noise
	task automatic queue_random_traffic(int unsigned goal);
		int unsigned added;
		int unsigned full_len;
		int unsigned pulses;
		int unsigned noise_len;
		// continue a leftover frame under the new register values
		pulses = $urandom_range(40);
		push_pulses(pulses);
		added = pulses;
		while (added < goal) begin
			if ($urandom_range(99) < 80) begin
				push_request(MODE_LOAD, 28'($urandom), 4'($urandom), 16'($urandom));
				full_len = frame_length();
				if ($urandom_range(99) < ((full_len <= 250) ? 40 : 12))
					pulses = full_len + $urandom_range(3);
				else
					pulses = $urandom_range(full_len - 1, 1);
				push_pulses(pulses);
				added += pulses + 1;
			end else begin
				noise_len = $urandom_range(5, 1);
				repeat (noise_len)
					push_request(1'($urandom), 28'($urandom), 4'($urandom), 16'($urandom));
				added += noise_len;
			end
		end
	endtask

	initial begin
		int unsigned burst_plan[8]  = '{0, 1, 2, 7, 1, 4, 1, 5};
		int unsigned header_plan[8] = '{0, 8, 3, 15, 0, 1, 2, 9};
		cfg_t        plan;
		shadow_cfg = '{short_time: 12'd750, long_time: 12'd1100, tolerance_time: 10'd160,
		               gap_time: 16'd15000, burst_total: 3'd3, header_pair_total: 4'd4};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle request, field extremes, counter wrap, reload mid-frame
		push_request(MODE_PULSE, 28'h0, 4'h0, 16'h0);
		push_request(MODE_LOAD, 28'hFFFFFFF, 4'hF, 16'hFFFF);
		push_pulses(4);
		push_request(MODE_LOAD, 28'h0, 4'h0, 16'h0);
		push_pulses(5);
		push_request(MODE_LOAD, 28'hAAAAAAA, 4'h5, 16'h5555);
		push_pulses(4);
		push_request(MODE_LOAD, 28'h5555555, 4'hA, 16'hAAAA);
		push_pulses(3);
		push_request(MODE_LOAD, 28'h8000000, 4'h1, 16'h7FFF);
		push_pulses(3);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 14;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
				0: begin
					plan.short_time     = 12'd0;
					plan.long_time      = 12'd0;
					plan.tolerance_time = 10'd0;
					plan.gap_time       = 16'd0;
				end
				1: begin
					plan.short_time     = 12'hFFF;
					plan.long_time      = 12'hFFF;
					plan.tolerance_time = 10'h3FF;
					plan.gap_time       = 16'hFFFF;
				end
				default: begin
					plan.short_time     = 12'($urandom);
					plan.long_time      = 12'($urandom);
					plan.tolerance_time = 10'($urandom);
					plan.gap_time       = 16'($urandom);
				end
			endcase
			plan.burst_total       = 3'(burst_plan[ph]);
			plan.header_pair_total = 4'(header_plan[ph]);
			// upper data bits beyond each register's width are dropped
			write_register(REG_SHORT_TIME, {4'($urandom), plan.short_time});
			write_register(REG_LONG_TIME, {4'($urandom), plan.long_time});
			write_register(REG_TOL_TIME, {6'($urandom), plan.tolerance_time});
			write_register(REG_GAP_TIME, plan.gap_time);
			write_register(REG_BURST_TOTAL, {13'($urandom), plan.burst_total});
			write_register(REG_HDR_TOTAL, {12'($urandom), plan.header_pair_total});
			@(posedge clk);
			cfg_we <= 1'b0;
			queue_random_traffic(100);
			if (ph == 6) begin
				// hold the receiver off so the block fills and backs up the sender
				repeat (20) @(posedge clk);
				hold_trigger <= 1'b1;
				@(posedge clk);
				hold_trigger <= 1'b0;
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d requests: %0d loads, %0d complete frames, %0d idle replies,",
		         requests_taken, loads_taken, frames_done, idle_replies);
		$display("over 9 register settings with sender/receiver idling and a long stall");
		if (pending_results.size() != 0)
			$display("%0d predicted results never arrived", pending_results.size());
		if (mismatch_total == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
